### hdl/bti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear table interpolator package
// Shared widths, codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package bti_pkg;

  // Table dimensions and value width.
  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int VALUE_W      = 32;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int AXIS_DEPTH   = 64;
  localparam int GRID_AW      = 2 * IDX_W;
  localparam int GRID_DEPTH   = MAX_X_POINTS * MAX_Y_POINTS;

  // Arithmetic widths: coordinate differences, multiplier, accumulator.
  localparam int DIFF_W = VALUE_W + 1;
  localparam int MOP_W  = VALUE_W + 2;
  localparam int PROD_W = 2 * MOP_W;
  localparam int ACC_W  = 100;
  localparam int DEN_W  = 2 * DIFF_W;
  localparam int DIV_STEPS = 32;

  // Request codes carried on the input channel.
  typedef enum logic [1:0] {
    REQ_WR_X    = 2'd0,
    REQ_WR_Y    = 2'd1,
    REQ_WR_GRID = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_X_USED = 1'b0,
    CFG_Y_USED = 1'b1
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_CHECK,
    ST_GRID,
    ST_MUL,
    ST_DEN,
    ST_DIVI,
    ST_DIV,
    ST_OUTW
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_START,
    CMD_SCAN_LAST,
    CMD_SCAN,
    CMD_PREP,
    CMD_GRID_RD,
    CMD_MUL_AB,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_ACC_HI,
    CMD_MUL_DEN,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [1:0]       sel;
    logic [4:0]       div_bit;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] scan_len;
    logic             degen;
  } status_t;

  // Command to one axis unit.
  typedef struct packed {
    logic             wr;
    logic             start;
    logic             rd_last;
    logic             rd;
    logic [IDX_W-1:0] addr;
  } axis_cmd_t;

  // Search result of one axis unit.
  typedef struct packed {
    logic                      ok;
    logic                      clamped;
    logic signed [VALUE_W-1:0] p;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    logic [IDX_W-1:0]          start;
  } axis_res_t;

endpackage

### hdl/bti_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear table interpolator axis unit
// Holds one axis store and scans it one point a cycle to clamp a coordinate
// and find the interval that brackets it.
// ----------------------------------------------------------------------------
module bti_axis (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bti_pkg::axis_cmd_t               cmd,
  input  logic signed [bti_pkg::VALUE_W-1:0] wr_data,
  input  logic signed [bti_pkg::VALUE_W-1:0] point,
  input  logic [bti_pkg::CNT_W-1:0]        n_used,
  output bti_pkg::axis_res_t               res
);
  import bti_pkg::*;

  logic signed [VALUE_W-1:0] mem [AXIS_DEPTH];
  logic signed [VALUE_W-1:0] rdata_r;
  logic                      tag_last_r;
  logic                      tag_rd_r;
  logic [IDX_W-1:0]          tag_idx_r;
  logic signed [VALUE_W-1:0] p_r, first_r, last_r, prev_r;
  logic signed [VALUE_W-1:0] lo1_r, lo2_r, hi1_r, hi2_r, hit1_r, hit2_r;
  logic                      found_r;
  logic [IDX_W-1:0]          hit_start_r;
  logic [CNT_W-1:0]          n_m1;
  logic [CNT_W-1:0]          n_m2;
  logic [IDX_W-1:0]          rd_addr;
  logic                      below, above;

  assign n_m1    = n_used - CNT_W'(1);
  assign n_m2    = n_used - CNT_W'(2);
  assign rd_addr = cmd.rd_last ? n_m1[IDX_W-1:0] : cmd.addr;

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= wr_data;
    end
    if (cmd.rd_last || cmd.rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Tags that travel with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_last_r <= 1'b0;
      tag_rd_r   <= 1'b0;
      tag_idx_r  <= '0;
    end else begin
      tag_last_r <= cmd.rd_last;
      tag_rd_r   <= cmd.rd;
      tag_idx_r  <= cmd.addr;
    end
  end

  // Scan: keep the first and last points, the first and last intervals and
  // the first interval that brackets the coordinate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.start) begin
      found_r <= 1'b0;
    end else if (tag_rd_r && ({1'b0, tag_idx_r} < n_used)) begin
      if (tag_idx_r != '0 && !found_r && prev_r <= p_r && p_r <= rdata_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r <= point;
    end
    if (tag_last_r) begin
      last_r <= rdata_r;
    end
    if (tag_rd_r && ({1'b0, tag_idx_r} < n_used)) begin
      prev_r <= rdata_r;
      if (tag_idx_r == '0) begin
        first_r <= rdata_r;
      end else begin
        if (tag_idx_r == IDX_W'(1)) begin
          lo1_r <= prev_r;
          lo2_r <= rdata_r;
        end
        if (tag_idx_r == n_m1[IDX_W-1:0]) begin
          hi1_r <= prev_r;
          hi2_r <= rdata_r;
        end
        if (!found_r && prev_r <= p_r && p_r <= rdata_r) begin
          hit1_r      <= prev_r;
          hit2_r      <= rdata_r;
          hit_start_r <= tag_idx_r - IDX_W'(1);
        end
      end
    end
  end

  // Clamp and select the interval.
  assign below = p_r < first_r;
  assign above = !below && (p_r > last_r);

  always_comb begin
    res.clamped = below || above;
    res.ok      = below || above || found_r;
    if (below) begin
      res.p     = first_r;
      res.lo    = lo1_r;
      res.hi    = lo2_r;
      res.start = '0;
    end else if (above) begin
      res.p     = last_r;
      res.lo    = hi1_r;
      res.hi    = hi2_r;
      res.start = n_m2[IDX_W-1:0];
    end else begin
      res.p     = p_r;
      res.lo    = hit1_r;
      res.hi    = hit2_r;
      res.start = hit_start_r;
    end
  end

endmodule

### hdl/bti_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear table interpolator datapath
// Configuration registers, axis units, grid store, shared multiplier,
// accumulator, serial divider and the result register.
// ----------------------------------------------------------------------------
module bti_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bti_pkg::cmd_t                      cmd,
  input  logic                               cfg_wr_en,
  input  logic [0:0]                         cfg_index,
  input  logic [bti_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic [1:0]                         in_req_type,
  input  logic [bti_pkg::IDX_W-1:0]          in_row_index,
  input  logic [bti_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_write_value,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_point_x,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_point_y,
  output logic signed [bti_pkg::VALUE_W-1:0] out_interp_value,
  output logic                               out_clamped_x,
  output logic                               out_clamped_y,
  output logic                               out_degenerate,
  output bti_pkg::status_t                   status
);
  import bti_pkg::*;

  logic [CNT_W-1:0] x_used_r, y_used_r, nx, ny;
  axis_cmd_t        xcmd, ycmd;
  axis_res_t        xres, yres;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_used_r <= CNT_W'(2);
      y_used_r <= CNT_W'(2);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_X_USED: x_used_r <= cfg_wr_data;
        CFG_Y_USED: y_used_r <= cfg_wr_data;
        default:    x_used_r <= x_used_r;
      endcase
    end
  end

  // Point counts limited to between 2 and the table size.
  assign nx = (x_used_r < CNT_W'(2)) ? CNT_W'(2) :
              (x_used_r > CNT_W'(MAX_X_POINTS)) ? CNT_W'(MAX_X_POINTS) : x_used_r;
  assign ny = (y_used_r < CNT_W'(2)) ? CNT_W'(2) :
              (y_used_r > CNT_W'(MAX_Y_POINTS)) ? CNT_W'(MAX_Y_POINTS) : y_used_r;
  assign status.scan_len = (nx > ny) ? nx : ny;

  // Axis unit commands.
  always_comb begin
    xcmd.wr      = (cmd.op == CMD_WRITE) && (in_req_type == REQ_WR_X);
    ycmd.wr      = (cmd.op == CMD_WRITE) && (in_req_type == REQ_WR_Y);
    xcmd.start   = (cmd.op == CMD_START);
    ycmd.start   = (cmd.op == CMD_START);
    xcmd.rd_last = (cmd.op == CMD_SCAN_LAST);
    ycmd.rd_last = (cmd.op == CMD_SCAN_LAST);
    xcmd.rd      = (cmd.op == CMD_SCAN);
    ycmd.rd      = (cmd.op == CMD_SCAN);
    xcmd.addr    = (cmd.op == CMD_WRITE) ? in_row_index : cmd.idx;
    ycmd.addr    = (cmd.op == CMD_WRITE) ? in_col_index : cmd.idx;
  end

  bti_axis u_x_axis (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (xcmd),
    .wr_data (in_write_value),
    .point   (in_point_x),
    .n_used  (nx),
    .res     (xres)
  );

  bti_axis u_y_axis (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ycmd),
    .wr_data (in_write_value),
    .point   (in_point_y),
    .n_used  (ny),
    .res     (yres)
  );

  // Interval differences, registered once the scan is over.
  logic signed [DIFF_W-1:0] dx_r, dy_r, a0_r, a1_r, b0_r, b1_r;
  logic signed [DIFF_W-1:0] dx_c, dy_c;
  logic                     clx_r, cly_r, degen_r;
  logic [IDX_W-1:0]         ix_r, iy_r;

  assign dx_c = DIFF_W'(xres.hi) - DIFF_W'(xres.lo);
  assign dy_c = DIFF_W'(yres.hi) - DIFF_W'(yres.lo);

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_PREP) begin
      dx_r    <= dx_c;
      dy_r    <= dy_c;
      a0_r    <= DIFF_W'(xres.hi) - DIFF_W'(xres.p);
      a1_r    <= DIFF_W'(xres.p) - DIFF_W'(xres.lo);
      b0_r    <= DIFF_W'(yres.hi) - DIFF_W'(yres.p);
      b1_r    <= DIFF_W'(yres.p) - DIFF_W'(yres.lo);
      clx_r   <= xres.clamped;
      cly_r   <= yres.clamped;
      degen_r <= !xres.ok || !yres.ok || (dx_c == '0) || (dy_c == '0);
      ix_r    <= xres.start;
      iy_r    <= yres.start;
    end
  end

  assign status.degen = degen_r;

  // Grid store, one registered read per cycle.
  logic signed [VALUE_W-1:0] grid [GRID_DEPTH];
  logic signed [VALUE_W-1:0] grid_q_r;
  logic signed [VALUE_W-1:0] f_r [4];
  logic                      gtag_r;
  logic [1:0]                gsel_r;
  logic [IDX_W-1:0]          g_row, g_col;

  assign g_row = ix_r + IDX_W'(cmd.sel[0]);
  assign g_col = iy_r + IDX_W'(cmd.sel[1]);

  always_ff @(posedge clk) begin
    if ((cmd.op == CMD_WRITE) && (in_req_type == REQ_WR_GRID)) begin
      grid[{in_row_index, in_col_index}] <= in_write_value;
    end
    if (cmd.op == CMD_GRID_RD) begin
      grid_q_r <= grid[{g_row, g_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gtag_r <= 1'b0;
      gsel_r <= '0;
    end else begin
      gtag_r <= (cmd.op == CMD_GRID_RD);
      gsel_r <= cmd.sel;
    end
  end

  always_ff @(posedge clk) begin
    if (gtag_r) begin
      f_r[gsel_r] <= grid_q_r;
    end
  end

  // Shared multiplier with its operand selection.
  logic signed [MOP_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] mul_res, prod_r;
  logic signed [DIFF_W-1:0] phi_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_comb begin
    case (cmd.op)
      CMD_MUL_AB: begin
        op_a = MOP_W'(cmd.sel[0] ? a1_r : a0_r);
        op_b = MOP_W'(cmd.sel[1] ? b1_r : b0_r);
      end
      CMD_MUL_LO: begin
        op_a = $signed({1'b0, prod_r[DIFF_W-1:0]});
        op_b = MOP_W'(f_r[cmd.sel]);
      end
      CMD_MUL_HI: begin
        op_a = MOP_W'(phi_r);
        op_b = MOP_W'(f_r[cmd.sel]);
      end
      CMD_MUL_DEN: begin
        op_a = MOP_W'(dx_r);
        op_b = MOP_W'(dy_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_MUL_AB || cmd.op == CMD_MUL_LO ||
        cmd.op == CMD_MUL_HI || cmd.op == CMD_MUL_DEN) begin
      prod_r <= mul_res;
    end
    if (cmd.op == CMD_MUL_LO) begin
      phi_r <= prod_r[2*DIFF_W-1:DIFF_W];
    end
  end

  // Accumulator of the four weighted corner values.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_PREP:   acc_r <= '0;
      CMD_MUL_HI: acc_r <= acc_r + ACC_W'(prod_r);
      CMD_ACC_HI: acc_r <= acc_r + $signed({prod_r[ACC_W-DIFF_W-1:0], {DIFF_W{1'b0}}});
      default:    acc_r <= acc_r;
    endcase
  end

  // Restoring divider, one quotient bit a cycle.
  logic [DEN_W-1:0]    den_r;
  logic [ACC_W-1:0]    rem_r, trial;
  logic [VALUE_W-1:0]  q_r;
  logic                neg_r;
  logic signed [PROD_W-1:0] prod_neg;
  logic signed [ACC_W-1:0]  acc_neg;

  assign prod_neg = -prod_r;
  assign acc_neg  = -acc_r;
  assign trial    = ACC_W'(den_r) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_DIV_INIT) begin
      den_r <= prod_r[PROD_W-1] ? prod_neg[DEN_W-1:0] : prod_r[DEN_W-1:0];
      rem_r <= acc_r[ACC_W-1] ? acc_neg : acc_r;
      neg_r <= prod_r[PROD_W-1] ^ acc_r[ACC_W-1];
      q_r   <= '0;
    end else if (cmd.op == CMD_DIV_STEP) begin
      if (rem_r >= trial) begin
        rem_r             <= rem_r - trial;
        q_r[cmd.div_bit]  <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD_OUT) begin
      out_interp_value <= degen_r ? '0 : (neg_r ? $signed(-q_r) : $signed(q_r));
      out_clamped_x    <= clx_r;
      out_clamped_y    <= cly_r;
      out_degenerate   <= degen_r;
    end
  end

endmodule

### hdl/bti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear table interpolator controller
// Sequences a query through scan, corner fetch, products, division and the
// result register, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module bti_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_req_type,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bti_pkg::status_t status,
  output bti_pkg::cmd_t    cmd
);
  import bti_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type == REQ_QUERY) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r == status.scan_len + CNT_W'(1)) begin
          state_nxt = ST_PREP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_PREP:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = status.degen ? ST_OUTW : ST_GRID;
      end
      ST_GRID: begin
        if (cnt_r == CNT_W'(4)) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(15)) begin
          state_nxt = ST_DEN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DEN:  state_nxt = ST_DIVI;
      ST_DIVI: begin
        state_nxt = ST_DIV;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_OUTW;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_OUTW: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath command.
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    cmd.op      = CMD_NONE;
    cmd.idx     = '0;
    cmd.sel     = '0;
    cmd.div_bit = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = (in_req_type == REQ_QUERY) ? CMD_START : CMD_WRITE;
        end
      end
      ST_SCAN: begin
        if (cnt_r == '0) begin
          cmd.op = CMD_SCAN_LAST;
        end else if (cnt_r <= status.scan_len) begin
          cmd.op  = CMD_SCAN;
          cmd.idx = IDX_W'(cnt_r - CNT_W'(1));
        end
      end
      ST_PREP: cmd.op = CMD_PREP;
      ST_GRID: begin
        if (cnt_r < CNT_W'(4)) begin
          cmd.op  = CMD_GRID_RD;
          cmd.sel = cnt_r[1:0];
        end
      end
      ST_MUL: begin
        cmd.sel = cnt_r[3:2];
        case (cnt_r[1:0])
          2'd0:    cmd.op = CMD_MUL_AB;
          2'd1:    cmd.op = CMD_MUL_LO;
          2'd2:    cmd.op = CMD_MUL_HI;
          default: cmd.op = CMD_ACC_HI;
        endcase
      end
      ST_DEN:  cmd.op = CMD_MUL_DEN;
      ST_DIVI: cmd.op = CMD_DIV_INIT;
      ST_DIV: begin
        cmd.op      = CMD_DIV_STEP;
        cmd.div_bit = cnt_r[4:0];
      end
      ST_OUTW: begin
        if (out_free) begin
          cmd.op = CMD_LOAD_OUT;
        end
      end
      default: cmd.op = CMD_NONE;
    endcase
  end

`ifndef ASSERT_OFF
  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CMD_LOAD_OUT) |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while a result waits");

  // An accepted query starts the scan at its first step.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == REQ_QUERY) |=>
      (state_r == ST_SCAN && cnt_r == '0))
    else $error("query did not start a scan");

  // A new result appears only from the result wait state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUTW))
    else $error("result raised outside the result wait state");

  // The scan counter never runs past the scan length plus one.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= status.scan_len + CNT_W'(1)))
    else $error("scan counter overran");
`endif

endmodule

### hdl/bilinear_table_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear table interpolator
// Grid table of ascending x and y axis points and values with a bilinear
// query, signed Q16.16 throughout.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel carries write requests (x point, y point, grid value)
//  and query requests. A write is stored when it is accepted and gives no
//  result. A query gives one result on the output channel: the interpolated
//  value, the two clamp flags and the degenerate flag.
//  The axis scan runs over N points, where N is the larger of the two point
//  counts, one point a cycle on both axes at once, and the divider gives one
//  quotient bit a cycle. A degenerate query skips the corner fetch, products
//  and division. One query is in work at a time; further requests are
//  stalled until the result has been placed in the output register, so the
//  next request can be taken while that result still waits for the
//  receiver. If the receiver stalls, the result is held unchanged and a
//  finished second query waits in the controller. Reset clears control
//  state and sets both point counts to 2; table contents are undefined
//  until written. The user is to write the point counts through the cfg
//  port only while the block idles; the block itself does not enforce this.
module bilinear_table_interpolator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [0:0]                         cfg_index,
  input  logic [bti_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [bti_pkg::IDX_W-1:0]          in_row_index,
  input  logic [bti_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_write_value,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_point_x,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_point_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bti_pkg::VALUE_W-1:0] out_interp_value,
  output logic                               out_clamped_x,
  output logic                               out_clamped_y,
  output logic                               out_degenerate
);
  import bti_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  bti_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Stores and arithmetic.
  bti_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_write_value   (in_write_value),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_interp_value (out_interp_value),
    .out_clamped_x    (out_clamped_x),
    .out_clamped_y    (out_clamped_y),
    .out_degenerate   (out_degenerate),
    .status           (status)
  );

endmodule
